@@ rtl/i2ra_pkg.sv @@
`timescale 1ns / 1ps

package i2ra_pkg;

    localparam int MAG_W      = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int MAX_DIGITS = 32;

    // quotient bits resolved per divider cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = MAG_W / DIV_BITS;
    localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic idx_load;
        logic put_sign;
        logic put_digit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic neg;
        logic idx_zero;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic up);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = (up ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ rtl/i2ra_ram.sv @@
`timescale 1ns / 1ps

module i2ra_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/i2ra_ctrl.sv @@
`timescale 1ns / 1ps

module i2ra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i2ra_pkg::t_status i_status,
    output i2ra_pkg::t_cmd    o_cmd
);

    i2ra_pkg::t_state r_state;
    i2ra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2ra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            i2ra_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i2ra_pkg::S_DIV;
                end
            end
            i2ra_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_done) begin
                    n_state = i2ra_pkg::S_SIGN;
                end
            end
            i2ra_pkg::S_SIGN: begin
                o_cmd.idx_load = 1'b1;
                if (!i_status.neg) begin
                    n_state = i2ra_pkg::S_READ;
                end else if (i_status.out_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_state        = i2ra_pkg::S_READ;
                end
            end
            i2ra_pkg::S_READ: begin
                n_state = i2ra_pkg::S_PUT;
            end
            i2ra_pkg::S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.put_digit = 1'b1;
                    n_state = i_status.idx_zero ? i2ra_pkg::S_IDLE : i2ra_pkg::S_READ;
                end
            end
            default: begin
                n_state = i2ra_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != i2ra_pkg::S_IDLE);

endmodule

@@ rtl/i2ra_datapath.sv @@
`timescale 1ns / 1ps

module i2ra_datapath #(
    parameter int MAX_DIGITS = i2ra_pkg::MAX_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [i2ra_pkg::MAG_W-1:0]   i_value,
    input  logic        [i2ra_pkg::RADIX_W-1:0] i_radix,
    input  logic                                i_upper,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic        [i2ra_pkg::CHAR_W-1:0]  o_out_char,
    output logic                                o_last,
    input  i2ra_pkg::t_cmd                      i_cmd,
    output i2ra_pkg::t_status                   o_status
);

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int MW = i2ra_pkg::MAG_W;
    localparam int DW = i2ra_pkg::DIGIT_W;

    logic [MW-1:0]                      r_mag;
    logic [MW-1:0]                      n_mag;
    logic [DW-1:0]                      r_rem;
    logic [DW-1:0]                      n_rem;
    logic [i2ra_pkg::RADIX_W-1:0]       r_base;
    logic                               r_upper;
    logic                               r_neg;
    logic [CW-1:0]                      r_cnt;
    logic [AW-1:0]                      r_idx;
    logic [i2ra_pkg::CHUNK_W-1:0]       r_chunk;
    logic                               r_oval;
    logic [i2ra_pkg::CHAR_W-1:0]        r_ochar;
    logic                               r_olast;

    logic                               chunk_last;
    logic                               room;
    logic                               we;
    logic                               out_free;
    logic                               radix_ok;
    logic [DW:0]                        trial;
    logic [DW-1:0]                      rd_digit;

    assign radix_ok   = (i_radix >= i2ra_pkg::RADIX_MIN) && (i_radix <= i2ra_pkg::RADIX_MAX);
    assign chunk_last = (r_chunk == i2ra_pkg::CHUNK_W'(i2ra_pkg::DIV_CHUNKS - 1));
    assign room       = (r_cnt < CW'(MAX_DIGITS));
    assign we         = i_cmd.div && chunk_last && room;
    assign out_free   = !r_oval || !i_out_stall;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        n_mag = r_mag;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < i2ra_pkg::DIV_BITS; k++) begin
            trial = {n_rem, n_mag[MW-1]};
            n_mag = {n_mag[MW-2:0], 1'b0};
            if (trial >= {1'b0, r_base}) begin
                n_rem    = DW'(trial - {1'b0, r_base});
                n_mag[0] = 1'b1;
            end else begin
                n_rem = trial[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_chunk <= '0;
            r_neg   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt   <= '0;
                r_chunk <= '0;
                r_neg   <= i_value[MW-1];
            end else if (i_cmd.div) begin
                r_chunk <= r_chunk + 1'b1;
                if (we) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.put_sign || i_cmd.put_digit) begin
                r_oval <= 1'b1;
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= i_value[MW-1] ? (MW'(0) - i_value) : i_value;
            r_rem   <= '0;
            r_base  <= radix_ok ? i_radix : i2ra_pkg::RADIX_DEFAULT;
            r_upper <= i_upper;
        end else if (i_cmd.div) begin
            r_mag <= n_mag;
            r_rem <= chunk_last ? '0 : n_rem;
        end
        if (i_cmd.idx_load) begin
            r_idx <= AW'(r_cnt - 1'b1);
        end else if (i_cmd.put_digit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.put_sign) begin
            r_ochar <= i2ra_pkg::CHAR_MINUS;
            r_olast <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_ochar <= i2ra_pkg::digit_char(rd_digit, r_upper);
            r_olast <= (r_idx == '0);
        end
    end

    i2ra_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(n_rem),
        .i_raddr(r_idx),
        .o_rdata(rd_digit)
    );

    assign o_status.div_done = i_cmd.div && chunk_last && (n_mag == '0);
    assign o_status.neg      = r_neg;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.out_free = out_free;

    assign o_out_valid = r_oval;
    assign o_out_char  = r_ochar;
    assign o_last      = r_olast;

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_digit |-> (CW'(r_idx) < r_cnt))
        else $error("digit read beyond stored count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div && chunk_last) |-> (n_rem < r_base))
        else $error("remainder not below radix");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_sign || i_cmd.put_digit) |-> (!r_oval || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_sign_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_sign |-> (r_neg && !i_cmd.put_digit))
        else $error("minus sign without negative value");

endmodule

@@ rtl/integer_to_radix_ascii.sv @@
`timescale 1ns / 1ps

// Signed 32-bit integer to ASCII text in radix 2..36 (any other radix acts as 10).
// Input channel: i_value, i_radix, i_upper with i_in_valid / o_in_stall; a transfer
// happens on a clock edge with valid high and stall low. One number is worked on at
// a time; o_in_stall is high from the transfer until the last character has been
// loaded into the output register.
// Output channel: o_out_char, o_last with o_out_valid / i_out_stall. Characters come
// most significant first, a minus sign ahead of a negative value, o_last on the final
// digit. Zero gives the single character "0".
// Steps for each number: load, then the divider (restoring divider, 8 quotient bits
// per cycle, 32-bit magnitude), a sign step, then for each digit a read of the
// registered digit store and a load of the output register.
// A stall on the output holds the current character in the output register and
// pauses emission; the next number is taken while the last character still waits.
// Reset (synchronous, active low) empties the output register and returns to idle.
// Digits beyond MAX_DIGITS are dropped from the most significant end.

module integer_to_radix_ascii #(
    parameter int MAX_DIGITS = i2ra_pkg::MAX_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [i2ra_pkg::MAG_W-1:0]   i_value,
    input  logic        [i2ra_pkg::RADIX_W-1:0] i_radix,
    input  logic                                i_upper,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic        [i2ra_pkg::CHAR_W-1:0]  o_out_char,
    output logic                                o_last
);

    i2ra_pkg::t_cmd    cmd;
    i2ra_pkg::t_status status;

    i2ra_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    i2ra_datapath #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_radix    (i_radix),
        .i_upper    (i_upper),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_char (o_out_char),
        .o_last     (o_last),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 260;

    typedef struct packed {
        logic [i2ra_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_char_exp;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [i2ra_pkg::MAG_W-1:0]  i_value;
    logic [i2ra_pkg::RADIX_W-1:0]       i_radix;
    logic                               i_upper;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [i2ra_pkg::CHAR_W-1:0]        o_out_char;
    logic                               o_last;

    t_char_exp   pending_chars[$];
    t_char_exp   front_char;
    int          mismatch_count;
    int unsigned cycle_count;
    bit          sender_gaps;
    bit          receiver_stalls;
    bit          hold_req;

    integer_to_radix_ascii u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_upper     (i_upper),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ASCII for one digit value
    function automatic logic [i2ra_pkg::CHAR_W-1:0] glyph(
        input logic [i2ra_pkg::DIGIT_W-1:0] d,
        input logic up);
        string lc;
        string uc;
        lc = "0123456789abcdefghijklmnopqrstuvwxyz";
        uc = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
        return up ? uc[d] : lc[d];
    endfunction

    // text of one number, pushed as expected characters
    function automatic void spell_number(input logic [i2ra_pkg::MAG_W-1:0] v,
                                         input logic [i2ra_pkg::RADIX_W-1:0] r,
                                         input logic up);
        logic [i2ra_pkg::MAG_W-1:0]   mag;
        logic [i2ra_pkg::MAG_W-1:0]   base;
        logic [i2ra_pkg::DIGIT_W-1:0] dig [i2ra_pkg::MAX_DIGITS];
        int                           cnt;
        t_char_exp                    e;
        base = (r < i2ra_pkg::RADIX_MIN || r > i2ra_pkg::RADIX_MAX)
             ? i2ra_pkg::MAG_W'(i2ra_pkg::RADIX_DEFAULT) : i2ra_pkg::MAG_W'(r);
        mag  = v[i2ra_pkg::MAG_W-1] ? (i2ra_pkg::MAG_W'(0) - v) : v;
        cnt  = 0;
        do begin
            if (cnt < i2ra_pkg::MAX_DIGITS) begin
                dig[cnt] = i2ra_pkg::DIGIT_W'(mag % base);
                cnt++;
            end
            mag = mag / base;
        end while (mag != 0);
        if (v[i2ra_pkg::MAG_W-1]) begin
            e.ch   = i2ra_pkg::CHAR_MINUS;
            e.last = 1'b0;
            pending_chars.push_back(e);
        end
        for (int i = cnt - 1; i >= 0; i--) begin
            e.ch   = glyph(dig[i], up);
            e.last = (i == 0);
            pending_chars.push_back(e);
        end
    endfunction

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t: unexpected char, expected none, got %h last %b",
                             $time, o_out_char, o_last);
            end else begin
                front_char = pending_chars.pop_front();
                if (o_out_char !== front_char.ch || o_last !== front_char.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $display("%0t: char mismatch, expected %h last %b, got %h last %b",
                                 $time, front_char.ch, front_char.last, o_out_char, o_last);
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        bit stall_val;
        int n;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_val = 1'b1;
                n         = HOLD_CYCLES;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                stall_val = 1'b1;
                n         = $urandom_range(1, 3);
            end else begin
                stall_val = 1'b0;
                n         = ($urandom_range(0, 9) == 0) ? 24 : $urandom_range(1, 4);
            end
            @(negedge i_clk);
            i_out_stall <= stall_val;
            repeat (n - 1) @(negedge i_clk);
        end
    end

    task automatic send_number(input logic signed [i2ra_pkg::MAG_W-1:0] v,
                               input logic [i2ra_pkg::RADIX_W-1:0] r,
                               input logic up);
        int gap;
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_radix    <= r;
        i_upper    <= up;
        do @(posedge i_clk); while (o_in_stall);
        spell_number(v, r, up);
    endtask

    task automatic send_random_number();
        logic signed [i2ra_pkg::MAG_W-1:0] v;
        logic [i2ra_pkg::RADIX_W-1:0]      r;
        logic                              up;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 1000);
            2: v = -$signed($urandom_range(0, 1000));
            default: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         ^ $urandom_range(0, 15);
        endcase
        r  = ($urandom_range(0, 4) == 0) ? i2ra_pkg::RADIX_W'($urandom_range(0, 63))
                                         : i2ra_pkg::RADIX_W'($urandom_range(2, 36));
        up = 1'($urandom_range(0, 1));
        send_number(v, r, up);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_text_drained();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_zero_and_unit();
        send_number(0, 10, 1'b0);
        send_number(0, 2, 1'b1);
        send_number(1, 10, 1'b0);
        send_number(-1, 16, 1'b0);
    endtask

    task automatic test_extremes();
        send_number(32'sh7FFF_FFFF, 2, 1'b0);
        send_number(32'sh8000_0000, 2, 1'b0);
        send_number(32'sh7FFF_FFFF, 10, 1'b1);
        send_number(32'sh8000_0000, 10, 1'b1);
        send_number(32'sh7FFF_FFFF, 16, 1'b0);
        send_number(32'sh8000_0000, 16, 1'b1);
        send_number(32'sh7FFF_FFFF, 36, 1'b1);
        send_number(32'sh8000_0000, 36, 1'b0);
    endtask

    task automatic test_radix_fallback();
        send_number(-12345, 0, 1'b0);
        send_number(99, 1, 1'b1);
        send_number(-987654321, 37, 1'b1);
        send_number(255, 63, 1'b0);
    endtask

    task automatic test_letter_case();
        send_number(35, 36, 1'b0);
        send_number(35, 36, 1'b1);
        send_number(-1295, 36, 1'b1);
        send_number(32'shDEAD_BEEF, 16, 1'b0);
        send_number(32'shCAFE_F00D, 16, 1'b1);
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count) send_random_number();
    endtask

    task automatic test_receiver_hold();
        hold_req = 1'b1;
        repeat (8) send_random_number();
    endtask

    task automatic test_sender_pause();
        repeat (10) send_random_number();
        idle_input();
        wait_text_drained();
        repeat (10) send_random_number();
    endtask

    task automatic test_final_stream();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (60) send_random_number();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_value         = '0;
        i_radix         = '0;
        i_upper         = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        hold_req        = 1'b0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_unit();
        test_extremes();
        test_radix_fallback();
        test_letter_case();
        test_random_numbers(150);
        test_receiver_hold();
        test_sender_pause();
        test_random_numbers(110);
        test_final_stream();

        idle_input();
        wait_text_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ integer_to_radix_ascii.f @@
rtl/i2ra_pkg.sv
rtl/i2ra_ram.sv
rtl/i2ra_ctrl.sv
rtl/i2ra_datapath.sv
rtl/integer_to_radix_ascii.sv
sim/tb_top.sv
